@@ rtl/acdi_pkg.sv @@
// Shared types and constants for the acceleration averaging depth integrator.
// Holds the word layouts of both channels and the configuration codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acdi_pkg;

  localparam int ACCEL_W     = 32;
  localparam int TIME_W      = 32;
  localparam int OUT_W       = 64;
  localparam int DIFF_W      = ACCEL_W + 1;
  localparam int WINDOW_W    = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [ACCEL_W-1:0]  OFFSET_RESET = 32'd17236;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd10;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_OFFSET = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 8'd1;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_sample;
    logic [TIME_W-1:0]         timestamp;
  } sample_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] depth;
    logic signed [OUT_W-1:0] velocity;
  } result_word_t;

endpackage

`default_nettype wire

@@ rtl/accel_average_depth_integrator_unit.sv @@
// Top level of the acceleration averaging depth integrator.
// Window control, sequencing and channel handshakes; uses acdi_pkg, acdi_ring,
// acdi_div and acdi_integ.
//
// The sample channel carries one word per item: an acceleration sample and its
// timestamp. A word is taken when sample_valid is high and sample_stall is low.
// sample_stall is high while an item is in progress, so items are handled one
// at a time. While the window fills, an item gives no result.
// Once the window is full, an item passes through the ring read, the divider,
// the integrator and the output stage, then the block is idle again. The
// window sum is SW bits wide (39 bits at a 64-entry window).
// The result word goes to an output register; the block takes the next sample
// while it waits. If a second result is ready while the receiver still stalls,
// the block holds it and keeps sample_stall high until the register frees.
// Configuration writes are taken in every cycle (cfg_ready is always high).
// Writing the window size restarts the window; velocity, depth and the last
// timestamp are kept. Reset clears the window, the accumulators and the
// registers to their reset values; the ring needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module accel_average_depth_integrator_unit
  import acdi_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire sample_word_t           sample,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output result_word_t                result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (NW > WINDOW_W) ? NW : WINDOW_W;
  localparam int SW = DIFF_W + $clog2(MAX_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DIV   = 5'b00100,
    S_INTEG = 5'b01000,
    S_OUT   = 5'b10000
  } top_state_t;

  top_state_t          state;
  logic [ACCEL_W-1:0]  accel_offset;
  logic [WINDOW_W-1:0] window_size;
  logic [PW-1:0]       wp;
  logic [NW-1:0]       fill;
  logic [SW-1:0]       window_sum;
  logic [TIME_W-1:0]   previous_time;
  logic [TIME_W-1:0]   ts_reg;
  logic [DIFF_W-1:0]   diff;
  logic                full;

  logic [CW-1:0]       ws_w;
  logic [CW-1:0]       n_w;
  logic [NW-1:0]       n;
  logic [NW:0]         old_ext;
  logic [PW-1:0]       old_addr;
  logic                accept;
  logic                cfg_we;
  logic [DIFF_W-1:0]   rd_data;
  logic [NW-1:0]       fill_next;
  logic [SW-1:0]       sum_next;
  logic [PW-1:0]       wp_next;
  logic                reached;

  logic                div_start;
  logic                div_done;
  logic                div_neg;
  logic [ACCEL_W-1:0]  div_quot;
  logic                integ_start;
  logic                integ_done;
  logic [OUT_W-1:0]    integ_depth;
  logic [OUT_W-1:0]    integ_velocity;
  logic                out_free;

  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  always_comb begin
    ws_w = CW'(window_size);
    n_w  = ws_w;
    if (ws_w == CW'(0)) begin
      n_w = CW'(1);
    end else if (ws_w > CW'(MAX_WINDOW)) begin
      n_w = CW'(MAX_WINDOW);
    end
    n = NW'(n_w);

    if ((NW + 1)'(wp) >= {1'b0, n}) begin
      old_ext = (NW + 1)'(wp) - {1'b0, n};
    end else begin
      old_ext = (NW + 1)'(wp) + (NW + 1)'(MAX_WINDOW) - {1'b0, n};
    end
    old_addr = PW'(old_ext);

    fill_next = full ? fill : (fill + NW'(1));
    reached   = (fill_next >= n);
    sum_next  = window_sum - (full ? SW'(signed'(rd_data)) : SW'(0))
                + SW'(signed'(diff));
    wp_next   = (wp == PW'(MAX_WINDOW - 1)) ? PW'(0) : (wp + PW'(1));

    div_start   = (state == S_READ) && reached;
    integ_start = (state == S_DIV) && div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      accel_offset  <= OFFSET_RESET;
      window_size   <= WINDOW_RESET;
      wp            <= '0;
      fill          <= '0;
      window_sum    <= '0;
      previous_time <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          fill       <= fill_next;
          window_sum <= sum_next;
          wp         <= wp_next;
          if (reached) begin
            state <= S_DIV;
          end else begin
            previous_time <= ts_reg;
            state         <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            previous_time <= ts_reg;
            state         <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (integ_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACCEL_OFFSET: accel_offset <= cfg_data[ACCEL_W-1:0];
          CFG_WINDOW_SIZE: begin
            window_size <= cfg_data[WINDOW_W-1:0];
            fill        <= '0;
            window_sum  <= '0;
            wp          <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ts_reg <= sample.timestamp;
      diff   <= DIFF_W'(sample.accel_sample) - DIFF_W'(signed'(accel_offset));
      full   <= (fill >= n);
    end
    if (state == S_OUT && out_free) begin
      result.depth    <= integ_depth;
      result.velocity <= integ_velocity;
    end
  end

  acdi_ring #(
    .DEPTH (MAX_WINDOW),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (old_addr),
    .rd_data (rd_data),
    .wr_en   (state == S_READ),
    .wr_addr (wp),
    .wr_data (diff)
  );

  acdi_div #(
    .SW (SW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (n),
    .done     (div_done),
    .neg      (div_neg),
    .quot     (div_quot)
  );

  acdi_integ u_integ (
    .clk      (clk),
    .rst      (rst),
    .start    (integ_start),
    .avg_neg  (div_neg),
    .avg_mag  (div_quot),
    .dt       (ts_reg - previous_time),
    .done     (integ_done),
    .depth    (integ_depth),
    .velocity (integ_velocity)
  );

endmodule

`default_nettype wire

@@ rtl/acdi_ring.sv @@
// Sample ring: synchronous memory of offset-corrected samples.
// One write port, one read port with registered read data. Uses acdi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acdi_ring
  import acdi_pkg::*;
#(
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DIFF_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DIFF_W-1:0] wr_data
);

  logic [DIFF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/acdi_div.sv @@
// Restoring divider that takes the window sum apart by the window length.
// One quotient bit per cycle, quotient truncated toward zero. Uses acdi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acdi_div
  import acdi_pkg::*;
#(
  parameter int SW = 39,
  parameter int NW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [SW-1:0] dividend,
  input  wire logic [NW-1:0] divisor,
  output logic               done,
  output logic               neg,
  output logic [ACCEL_W-1:0] quot
);

  localparam int CNT_W = $clog2(SW + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [SW-1:0]    dvd;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    dsr;
  logic [NW:0]      trial;
  logic             qbit;

  always_comb begin
    trial = {rem, dvd[SW-1]};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(SW);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SW-1];
      dvd <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[SW-2:0], qbit};
      rem <= qbit ? NW'(trial - {1'b0, dsr}) : NW'(trial);
    end
  end

  assign quot = dvd[ACCEL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/acdi_integ.sv @@
// Double integrator: velocity and depth accumulators with saturation.
// One shared 32 by 32 multiplier is stepped by a small sequencer. Uses acdi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acdi_integ
  import acdi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               avg_neg,
  input  wire logic [ACCEL_W-1:0] avg_mag,
  input  wire logic [TIME_W-1:0]  dt,
  output logic                    done,
  output logic [OUT_W-1:0]        depth,
  output logic [OUT_W-1:0]        velocity
);

  typedef enum logic [7:0] {
    I_IDLE  = 8'b0000_0001,
    I_MULV  = 8'b0000_0010,
    I_VADD  = 8'b0000_0100,
    I_MAGV  = 8'b0000_1000,
    I_MULD0 = 8'b0001_0000,
    I_MULD1 = 8'b0010_0000,
    I_COMB  = 8'b0100_0000,
    I_DADD  = 8'b1000_0000
  } integ_state_t;

  localparam logic [OUT_W-1:0] SIGN_BIT = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] acc,
                                               input logic             sub,
                                               input logic [OUT_W-1:0] mag,
                                               input logic             huge);
    logic [OUT_W-1:0] u;
    logic [OUT_W:0]   s;
    logic [OUT_W-1:0] r;
    u = acc ^ SIGN_BIT;
    s = {1'b0, u} + {1'b0, mag};
    if (!sub) begin
      r = (huge || s[OUT_W]) ? (SIGN_BIT - OUT_W'(1)) : (s[OUT_W-1:0] ^ SIGN_BIT);
    end else begin
      r = (huge || (mag > u)) ? SIGN_BIT : ((u - mag) ^ SIGN_BIT);
    end
    return r;
  endfunction

  integ_state_t      state;
  logic              neg;
  logic [OUT_W-1:0]  opa;
  logic [TIME_W-1:0] dt_reg;
  logic [63:0]       prod_lo;
  logic [63:0]       prod_hi;
  logic [95:0]       prod_full;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  logic [OUT_W-1:0]  vstep;
  logic [76:0]       dstep;
  logic              dround;

  always_comb begin
    mul_a  = (state == I_MULD1) ? opa[63:32] : opa[31:0];
    mul_p  = {32'b0, mul_a} * {32'b0, dt_reg};
    vstep  = OUT_W'(prod_lo[63:20]) + OUT_W'(neg && (prod_lo[19:0] != 20'd0));
    dround = neg && (prod_full[19:0] != 20'd0);
    dstep  = {1'b0, prod_full[95:20]} + 77'(dround);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= I_IDLE;
      done     <= 1'b0;
      velocity <= '0;
      depth    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        I_IDLE: begin
          if (start) begin
            state <= I_MULV;
          end
        end
        I_MULV:  state <= I_VADD;
        I_VADD: begin
          velocity <= sat_add(velocity, neg, vstep, 1'b0);
          state    <= I_MAGV;
        end
        I_MAGV:  state <= I_MULD0;
        I_MULD0: state <= I_MULD1;
        I_MULD1: state <= I_COMB;
        I_COMB:  state <= I_DADD;
        I_DADD: begin
          depth <= sat_add(depth, neg, dstep[63:0], dstep[76:64] != 13'd0);
          done  <= 1'b1;
          state <= I_IDLE;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == I_IDLE && start) begin
      neg    <= avg_neg;
      opa    <= OUT_W'(avg_mag);
      dt_reg <= dt;
    end
    if (state == I_MULV || state == I_MULD0) begin
      prod_lo <= mul_p;
    end
    if (state == I_MAGV) begin
      neg <= velocity[OUT_W-1];
      opa <= velocity[OUT_W-1] ? (~velocity + OUT_W'(1)) : velocity;
    end
    if (state == I_MULD1) begin
      prod_hi <= mul_p;
    end
    if (state == I_COMB) begin
      prod_full <= {prod_hi, 32'b0} + {32'b0, prod_lo};
    end
  end

endmodule

`default_nettype wire
